// ===== hdl/ccf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types and constants of the cubic curve flattener.
// ----------------------------------------------------------------------------
`default_nettype none

package ccf_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BEZ_DETAIL   = 2'd0,
    CFG_CURVE_DETAIL = 2'd1,
    CFG_TIGHTNESS    = 2'd2
  } ccf_cfg_e;

  // actions
  localparam logic ACT_BEZIER   = 1'b0;
  localparam logic ACT_CARDINAL = 1'b1;

  // per-point control from the sequencer into the datapath
  typedef struct packed {
    logic valid;
    logic last;
    logic card;
  } ccf_ctl_t;

  // integer part of the t step, 65536 / d, indexed by the segment count d
  localparam logic [16:0] TSTEP_Q [64] = '{
    17'd0,          17'(65536 / 1),  17'(65536 / 2),  17'(65536 / 3),
    17'(65536 / 4),  17'(65536 / 5),  17'(65536 / 6),  17'(65536 / 7),
    17'(65536 / 8),  17'(65536 / 9),  17'(65536 / 10), 17'(65536 / 11),
    17'(65536 / 12), 17'(65536 / 13), 17'(65536 / 14), 17'(65536 / 15),
    17'(65536 / 16), 17'(65536 / 17), 17'(65536 / 18), 17'(65536 / 19),
    17'(65536 / 20), 17'(65536 / 21), 17'(65536 / 22), 17'(65536 / 23),
    17'(65536 / 24), 17'(65536 / 25), 17'(65536 / 26), 17'(65536 / 27),
    17'(65536 / 28), 17'(65536 / 29), 17'(65536 / 30), 17'(65536 / 31),
    17'(65536 / 32), 17'(65536 / 33), 17'(65536 / 34), 17'(65536 / 35),
    17'(65536 / 36), 17'(65536 / 37), 17'(65536 / 38), 17'(65536 / 39),
    17'(65536 / 40), 17'(65536 / 41), 17'(65536 / 42), 17'(65536 / 43),
    17'(65536 / 44), 17'(65536 / 45), 17'(65536 / 46), 17'(65536 / 47),
    17'(65536 / 48), 17'(65536 / 49), 17'(65536 / 50), 17'(65536 / 51),
    17'(65536 / 52), 17'(65536 / 53), 17'(65536 / 54), 17'(65536 / 55),
    17'(65536 / 56), 17'(65536 / 57), 17'(65536 / 58), 17'(65536 / 59),
    17'(65536 / 60), 17'(65536 / 61), 17'(65536 / 62), 17'(65536 / 63)
  };

endpackage

`default_nettype wire

// ===== hdl/ccf_seq.sv =====
// ----------------------------------------------------------------------------
// ccf_seq
// Holds one curve and steps t = j/d over its points, one point per cycle while adv_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_seq import ccf_pkg::*; #(
  parameter int CoordWidth = 24,
  parameter int MaxDetail  = 63
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           in_card_i,
  input  wire logic [8*CoordWidth-1:0]        in_pts_i,
  input  wire logic [5:0]                     bez_detail_i,
  input  wire logic [5:0]                     curve_detail_i,
  input  wire logic signed [15:0]             tightness_i,
  input  wire logic                           adv_i,
  output ccf_ctl_t                            ctl_o,
  output logic [16:0]                         t_o,
  output logic [8*CoordWidth-1:0]             pts_o,
  output logic signed [16:0]                  k_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  d_q, d_d;
  logic [16:0] t_q, t_d;
  logic [5:0]  r_q, r_d;
  logic [16:0] qstep_q, qstep_d;
  logic [5:0]  rstep_q, rstep_d;
  logic        card_q, card_d;
  logic [8*CoordWidth-1:0] pts_q, pts_d;
  logic signed [16:0] k_q, k_d;

  logic        accept, issue, last;
  logic [5:0]  d_sel, d_cl;
  logic [16:0] q_sel;
  logic [17:0] r_full;
  logic [6:0]  r_sum;

  // detail clamp and t step split into quotient and remainder
  always_comb begin
    d_sel = in_card_i ? curve_detail_i : bez_detail_i;
    if (d_sel == 6'd0) begin
      d_cl = 6'd1;
    end else if (d_sel > 6'(MaxDetail)) begin
      d_cl = 6'(MaxDetail);
    end else begin
      d_cl = d_sel;
    end
    q_sel  = TSTEP_Q[d_cl];
    r_full = 18'd65536 - 18'(q_sel * d_cl);
  end

  assign accept = in_valid_i & ~busy_q;
  assign issue  = busy_q & adv_i;
  assign last   = (cnt_q == d_q);
  assign r_sum  = {1'b0, r_q} + {1'b0, rstep_q};

  // next state
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    t_d     = t_q;
    r_d     = r_q;
    qstep_d = qstep_q;
    rstep_d = rstep_q;
    card_d  = card_q;
    pts_d   = pts_q;
    k_d     = k_q;
    if (accept) begin
      busy_d  = 1'b1;
      cnt_d   = 6'd0;
      d_d     = d_cl;
      t_d     = 17'd0;
      r_d     = d_cl >> 1;
      qstep_d = q_sel;
      rstep_d = r_full[5:0];
      card_d  = in_card_i;
      pts_d   = in_pts_i;
      k_d     = 17'sd4096 - 17'(tightness_i);
    end else if (issue) begin
      cnt_d = cnt_q + 6'd1;
      if (last) begin
        busy_d = 1'b0;
      end
      if (r_sum >= {1'b0, d_q}) begin
        t_d = t_q + qstep_q + 17'd1;
        r_d = 6'(r_sum - {1'b0, d_q});
      end else begin
        t_d = t_q + qstep_q;
        r_d = r_sum[5:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // curve data
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    d_q     <= d_d;
    t_q     <= t_d;
    r_q     <= r_d;
    qstep_q <= qstep_d;
    rstep_q <= rstep_d;
    card_q  <= card_d;
    pts_q   <= pts_d;
    k_q     <= k_d;
  end

  assign in_ready_o  = ~busy_q;
  assign ctl_o.valid = busy_q;
  assign ctl_o.last  = last;
  assign ctl_o.card  = card_q;
  assign t_o         = t_q;
  assign pts_o       = pts_q;
  assign k_o         = k_q;

  // checks
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= d_q) else $error("point count beyond detail");
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> r_q < d_q) else $error("t remainder out of range");
  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last) |=> !busy_q) else $error("curve did not end on last point");
  a_last_t_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && last) |-> t_q == 17'd65536) else $error("final t is not one");

endmodule

`default_nettype wire

// ===== hdl/ccf_dp.sv =====
// ----------------------------------------------------------------------------
// ccf_dp
// Seven-stage point datapath: Bezier weights and cardinal polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_dp import ccf_pkg::*; #(
  parameter int CoordWidth = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire ccf_ctl_t                      ctl_i,
  input  wire logic [16:0]                   t_i,
  input  wire logic [8*CoordWidth-1:0]       pts_i,
  input  wire logic signed [16:0]            k_i,
  output logic                               valid_o,
  output logic                               last_o,
  output logic signed [CoordWidth-1:0]       x_o,
  output logic signed [CoordWidth-1:0]       y_o
);

  localparam int CW = CoordWidth;
  localparam int WW = CW + 35;
  localparam logic signed [WW-1:0] SatMax = WW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SatMin = -SatMax - WW'(1);

  typedef struct {
    logic                 last;
    logic                 card;
    logic [16:0]          t;
    logic [16:0]          m;
    logic signed [CW-1:0] p [2][4];
    logic signed [CW+3:0] ca [2];
    logic signed [CW+4:0] cb [2];
    logic signed [CW+1:0] cc [2];
    logic signed [16:0]   k;
    logic [33:0]          m2;
    logic [33:0]          mt;
    logic [33:0]          tt;
    logic [49:0]          w [4];
    logic [30:0]          wr [4];
    logic [16:0]          ct2;
    logic [16:0]          ct3;
    logic signed [CW+31:0] bp [2][4];
    logic signed [CW+21:0] cp [2][3];
    logic signed [CW-1:0] bres [2];
    logic signed [CW+16:0] s [2];
    logic signed [WW-1:0] acc [2];
    logic signed [CW-1:0] res [2];
  } st_t;

  function automatic logic signed [CW-1:0] sat_f(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    begin
      r = v;
      if (v > SatMax) r = SatMax;
      if (v < SatMin) r = SatMin;
      return r[CW-1:0];
    end
  endfunction

  st_t        st_q [1:7];
  st_t        st_d [0:7];
  logic [7:1] v_q;

  // stage 0: unpack the curve held by the sequencer
  always_comb begin
    st_d[0] = st_q[1];
    st_d[0].last = ctl_i.last;
    st_d[0].card = ctl_i.card;
    st_d[0].t    = t_i;
    st_d[0].k    = k_i;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 4; i++) begin
        st_d[0].p[c][i] = pts_i[(2*i+c)*CW +: CW];
      end
    end
  end

  // stage 1: powers of t and 1-t, cardinal coefficients
  always_comb begin
    st_d[1] = st_d[0];
    st_d[1].m  = 17'(18'd65536 - 18'(st_d[0].t));
    st_d[1].m2 = 34'(st_d[1].m) * 34'(st_d[1].m);
    st_d[1].mt = 34'(st_d[1].m) * 34'(st_d[0].t);
    st_d[1].tt = 34'(st_d[0].t) * 34'(st_d[0].t);
    for (int c = 0; c < 2; c++) begin
      st_d[1].ca[c] = -(CW+4)'(st_d[0].p[c][0]) + (CW+4)'(3) * (CW+4)'(st_d[0].p[c][1])
                      - (CW+4)'(3) * (CW+4)'(st_d[0].p[c][2]) + (CW+4)'(st_d[0].p[c][3]);
      st_d[1].cb[c] = (CW+5)'(2) * (CW+5)'(st_d[0].p[c][0])
                      - (CW+5)'(5) * (CW+5)'(st_d[0].p[c][1])
                      + (CW+5)'(4) * (CW+5)'(st_d[0].p[c][2]) - (CW+5)'(st_d[0].p[c][3]);
      st_d[1].cc[c] = (CW+2)'(st_d[0].p[c][2]) - (CW+2)'(st_d[0].p[c][0]);
    end
  end

  // stage 2: exact Bezier weights, cardinal t squared
  always_comb begin
    st_d[2] = st_q[1];
    st_d[2].w[0] = 50'(st_q[1].m2) * 50'(st_q[1].m);
    st_d[2].w[1] = 50'(3) * (50'(st_q[1].m2) * 50'(st_q[1].t));
    st_d[2].w[2] = 50'(3) * (50'(st_q[1].mt) * 50'(st_q[1].t));
    st_d[2].w[3] = 50'(st_q[1].tt) * 50'(st_q[1].t);
    st_d[2].ct2  = 17'((35'(st_q[1].tt) + 35'd32768) >> 16);
  end

  // stage 3: weights to Q0.30, cardinal t cubed
  always_comb begin
    st_d[3] = st_q[2];
    for (int i = 0; i < 4; i++) begin
      st_d[3].wr[i] = 31'((51'(st_q[2].w[i]) + 51'd131072) >> 18);
    end
    st_d[3].ct3 = 17'((35'(st_q[2].ct2) * 35'(st_q[2].t) + 35'd32768) >> 16);
  end

  // stage 4: coordinate products
  always_comb begin
    st_d[4] = st_q[3];
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 4; i++) begin
        st_d[4].bp[c][i] = (CW+32)'($signed({1'b0, st_q[3].wr[i]}))
                           * (CW+32)'(st_q[3].p[c][i]);
      end
      st_d[4].cp[c][0] = (CW+22)'(st_q[3].ca[c]) * (CW+22)'($signed({1'b0, st_q[3].ct3}));
      st_d[4].cp[c][1] = (CW+22)'(st_q[3].cb[c]) * (CW+22)'($signed({1'b0, st_q[3].ct2}));
      st_d[4].cp[c][2] = (CW+22)'(st_q[3].cc[c]) * (CW+22)'($signed({1'b0, st_q[3].t}));
    end
  end

  // stage 5: Bezier sum and rounding, cardinal polynomial rounded to Q.8
  always_comb begin
    logic signed [WW-1:0] bsum;
    logic signed [WW-1:0] csum;
    st_d[5] = st_q[4];
    for (int c = 0; c < 2; c++) begin
      bsum = WW'(st_q[4].bp[c][0]) + WW'(st_q[4].bp[c][1])
           + WW'(st_q[4].bp[c][2]) + WW'(st_q[4].bp[c][3]) + (WW'(1) <<< 29);
      st_d[5].bres[c] = sat_f(bsum >>> 30);
      csum = WW'(st_q[4].cp[c][0]) + WW'(st_q[4].cp[c][1])
           + WW'(st_q[4].cp[c][2]) + WW'(128);
      st_d[5].s[c] = (CW+17)'(csum >>> 8);
    end
  end

  // stage 6: tightness scaling plus the second point
  always_comb begin
    st_d[6] = st_q[5];
    for (int c = 0; c < 2; c++) begin
      st_d[6].acc[c] = WW'(st_q[5].s[c]) * WW'(st_q[5].k)
                     + (WW'(st_q[5].p[c][1]) <<< 21);
    end
  end

  // stage 7: cardinal rounding, saturation and result select
  always_comb begin
    st_d[7] = st_q[6];
    for (int c = 0; c < 2; c++) begin
      if (st_q[6].card == ACT_CARDINAL) begin
        st_d[7].res[c] = sat_f((st_q[6].acc[c] + (WW'(1) <<< 20)) >>> 21);
      end else begin
        st_d[7].res[c] = st_q[6].bres[c];
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[6:1], ctl_i.valid};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 1; i <= 7; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o = v_q[7];
  assign last_o  = st_q[7].last;
  assign x_o     = st_q[7].res[0];
  assign y_o     = st_q[7].res[1];

endmodule

`default_nettype wire

// ===== hdl/cubic_curve_flattener_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_curve_flattener_unit
// Flattens cubic Bezier curves and cardinal spline segments into points.
// ----------------------------------------------------------------------------
// Each accepted curve yields d+1 points, one per cycle while the output side
// takes them, where d is the clamped Bezier or cardinal detail; the sequencer
// takes no new curve while it issues one, and can take the next curve in the
// cycle after it issues the last point. Points travel through a seven-stage
// datapath (multiplier stages for the weights and products), and the output
// register stalls the whole pipeline when the output is not ready.
`default_nettype none

module cubic_curve_flattener_unit import ccf_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8,
  parameter int MAX_DETAIL  = 63
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input curve
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  wire logic [8*COORD_WIDTH-1:0]      s_axis_tdata,
  // action
  input  wire logic                          s_axis_tuser,
  // output points
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // point_x, point_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                               m_axis_tlast,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i
);

  localparam int OutW = ((2*COORD_WIDTH+7)/8)*8;
  // fraction bits do not change the arithmetic, which is linear in the points
  localparam int FracUnused = FRAC_BITS;

  logic [5:0]         bez_detail_q;
  logic [5:0]         curve_detail_q;
  logic signed [15:0] tightness_q;

  ccf_ctl_t                    ctl;
  logic [16:0]                 t;
  logic [8*COORD_WIDTH-1:0]    pts;
  logic signed [16:0]          k;
  logic                        adv;
  logic signed [COORD_WIDTH-1:0] x, y;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bez_detail_q   <= 6'd20;
      curve_detail_q <= 6'd20;
      tightness_q    <= 16'sd0;
    end else if (cfg_we_i && FracUnused >= 0) begin
      unique case (cfg_idx_i)
        CFG_BEZ_DETAIL:   bez_detail_q   <= cfg_data_i[5:0];
        CFG_CURVE_DETAIL: curve_detail_q <= cfg_data_i[5:0];
        CFG_TIGHTNESS:    tightness_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being taken
  assign adv = ~m_axis_tvalid | m_axis_tready;

  ccf_seq #(
    .CoordWidth (COORD_WIDTH),
    .MaxDetail  (MAX_DETAIL)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_card_i      (s_axis_tuser),
    .in_pts_i       (s_axis_tdata),
    .bez_detail_i   (bez_detail_q),
    .curve_detail_i (curve_detail_q),
    .tightness_i    (tightness_q),
    .adv_i          (adv),
    .ctl_o          (ctl),
    .t_o            (t),
    .pts_o          (pts),
    .k_o            (k)
  );

  ccf_dp #(
    .CoordWidth (COORD_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (ctl),
    .t_i     (t),
    .pts_i   (pts),
    .k_i     (k),
    .valid_o (m_axis_tvalid),
    .last_o  (m_axis_tlast),
    .x_o     (x),
    .y_o     (y)
  );

  assign m_axis_tdata = OutW'({y, x});

endmodule

`default_nettype wire

// ===== tb/cubic_curve_flattener_unit_checker.sv =====
// ----------------------------------------------------------------------------
// cubic_curve_flattener_unit_checker
// Watches the config port and both streams, predicts every curve point from
// its own copy of the registers and compares each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cubic_curve_flattener_unit_checker import ccf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [191:0] s_tdata_i,
  input  wire logic         s_tuser_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [47:0]  m_tdata_i,
  input  wire logic         m_tlast_i,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  output int                points_pending_o,
  output int                fail_count_o
);

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               last;
  } curve_point_t;

  curve_point_t point_q[$];
  logic [5:0]         bez_detail;
  logic [5:0]         crv_detail;
  logic signed [15:0] tight;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [23:0] sat_coord(longint v);
    if (v > 64'sd8388607) return 24'h7fffff;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // one coordinate of the curve at parameter t (Q0.16)
  function automatic longint eval_coord(logic card, longint p0, longint p1,
                                        longint p2, longint p3, longint t,
                                        longint k);
    longint m, t2, t3, a, b, c, s, acc;
    if (card) begin
      t2 = (t * t + 32768) >> 16;
      t3 = (t2 * t + 32768) >> 16;
      a = -p0 + 3 * p1 - 3 * p2 + p3;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = p2 - p0;
      s = rnd_shift(a * t3 + b * t2 + c * t, 8);
      return rnd_shift(s * k + p1 * (longint'(1) << 21), 21);
    end
    m = 65536 - t;
    acc = ((m * m * m + 131072) >> 18) * p0
        + ((3 * m * m * t + 131072) >> 18) * p1
        + ((3 * m * t * t + 131072) >> 18) * p2
        + ((t * t * t + 131072) >> 18) * p3;
    return rnd_shift(acc, 30);
  endfunction

  // expand one curve into its points
  task automatic predict_curve(logic card, logic [191:0] pts);
    longint px[4], py[4];
    longint d, t, k;
    curve_point_t cp;
    for (int i = 0; i < 4; i++) begin
      px[i] = longint'($signed(pts[48*i +: 24]));
      py[i] = longint'($signed(pts[48*i + 24 +: 24]));
    end
    d = card ? crv_detail : bez_detail;
    if (d < 1) d = 1;
    k = 4096 - longint'(tight);
    for (longint j = 0; j <= d; j++) begin
      t = (j * 65536 + d / 2) / d;
      cp.x = sat_coord(eval_coord(card, px[0], px[1], px[2], px[3], t, k));
      cp.y = sat_coord(eval_coord(card, py[0], py[1], py[2], py[3], t, k));
      cp.last = (j == d);
      point_q.push_back(cp);
    end
  endtask

  // shadow registers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bez_detail <= 6'd20;
      crv_detail <= 6'd20;
      tight      <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEZ_DETAIL:   bez_detail <= cfg_data_i[5:0];
        CFG_CURVE_DETAIL: crv_detail <= cfg_data_i[5:0];
        CFG_TIGHTNESS:    tight      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // predict on input transfers, compare on output transfers
  initial fail_count_o = 0;
  always @(posedge clk_i) begin
    curve_point_t exp_pt;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (point_q.size() == 0) begin
          $error("unexpected point transfer x=%h y=%h", m_tdata_i[23:0],
                 m_tdata_i[47:24]);
          fail_count_o++;
        end else begin
          exp_pt = point_q.pop_front();
          if (m_tdata_i[23:0] !== exp_pt.x) begin
            $error("point_x expected %h actual %h", exp_pt.x, m_tdata_i[23:0]);
            fail_count_o++;
          end
          if (m_tdata_i[47:24] !== exp_pt.y) begin
            $error("point_y expected %h actual %h", exp_pt.y, m_tdata_i[47:24]);
            fail_count_o++;
          end
          if (m_tlast_i !== exp_pt.last) begin
            $error("last expected %b actual %b", exp_pt.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) predict_curve(s_tuser_i, s_tdata_i);
    end
    points_pending_o = point_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/cubic_curve_flattener_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cubic_curve_flattener_unit_tb
// Drives directed and random Bezier and cardinal curves through the flattener
// under several detail and tightness settings, with bursty input, random
// output stalls and one long output hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cubic_curve_flattener_unit_tb;
  import ccf_pkg::*;

  localparam logic [1:0] CFG_NO_REG = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  logic         s_tuser = 1'b0; // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;        // point_x, point_y
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = '0;
  logic [15:0]  cfg_data = '0;
  int           points_pending;
  int           fail_count;
  int           cyc = 0;
  logic         hold_req = 1'b0;
  int           hold_cnt = 0;

  cubic_curve_flattener_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  cubic_curve_flattener_unit_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready),
    .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready),
    .m_tdata_i(m_tdata), .m_tlast_i(m_tlast),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .points_pending_o(points_pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: stall pattern chosen by bits 9:8 of the cycle count, plus a long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_cnt <= 1500;
      m_tready <= 1'b0;
    end else begin
      case ((cyc >> 8) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(1, 0));
        2: m_tready <= ($urandom_range(3, 0) == 0);
        default: m_tready <= ((cyc % 16) < 11);
      endcase
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(2000, 0)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  // offer one curve and wait for its transfer
  task automatic send_curve(logic act, logic [191:0] pts);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= pts;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_random(int count);
    logic [191:0] pts;
    int gap;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 8; i++) pts[24*i +: 24] = rand_coord();
      send_curve(1'($urandom_range(1, 0)), pts);
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 1) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // let every expected point arrive, then settle the pipeline
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (points_pending != 0) @(negedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] bez, logic [15:0] crv, logic [15:0] tgt);
    drain();
    write_reg(CFG_BEZ_DETAIL, bez);
    write_reg(CFG_CURVE_DETAIL, crv);
    write_reg(CFG_TIGHTNESS, tgt);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes of every coordinate with both actions, reset config
    for (int a = 0; a < 2; a++) begin
      send_curve(1'(a), '0);
      send_curve(1'(a), {8{24'h7fffff}});
      send_curve(1'(a), {8{24'h800000}});
      send_curve(1'(a), {4{24'h800000, 24'h7fffff}});
      send_curve(1'(a), {24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                         24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff});
    end

    // smallest Bezier detail, largest cardinal detail, most negative tightness: cardinal overshoot saturates
    set_config(16'd1, 16'd63, 16'h8000);
    send_curve(ACT_CARDINAL, {4{24'h800000, 24'h7fffff}});
    send_curve(ACT_CARDINAL, {24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                              24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff});
    send_curve(ACT_BEZIER, {8{24'h7fffff}});

    // largest Bezier detail, smallest cardinal detail, largest tightness
    set_config(16'd63, 16'd1, 16'h7fff);
    send_curve(ACT_BEZIER, {4{24'h800000, 24'h7fffff}});
    send_curve(ACT_CARDINAL, {4{24'h7fffff, 24'h800000}});

    // zero detail, values wider than the register, a write to no register
    set_config(16'd0, 16'hffc0, 16'd0);
    write_reg(CFG_NO_REG, 16'hffff);
    send_curve(ACT_BEZIER, {8{24'h123456}});
    send_curve(ACT_CARDINAL, {8{24'hfedcba}});
    set_config(16'hff85, 16'h5503, 16'h1000);
    send_curve(ACT_BEZIER, {8{24'h7fffff}});
    send_curve(ACT_CARDINAL, {4{24'h800000, 24'h7fffff}});

    // random phases under varied settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(16'd2, 16'd3, 16'h8000);
        1: set_config(16'd63, 16'd63, 16'h7fff);
        default: set_config(16'($urandom_range(16, 1)), 16'($urandom_range(16, 1)),
                            16'($urandom));
      endcase
      if (ph == 2) begin
        send_random(5);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
        send_random(55);
      end else begin
        send_random(60);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
